// ===== src/qsat_pkg.sv =====
package qsat_pkg;

  // Coordinate precision; each corner field is read from its low COORD_BITS bits.
  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned NUM_CORNERS = 4;
  localparam int unsigned NUM_COORDS  = 2 * NUM_CORNERS;
  localparam int unsigned NUM_AXES    = 4;
  localparam int unsigned NUM_PROJ    = 2 * NUM_CORNERS;

  // Difference of two coordinates, product of axis and coordinate, sum of two products.
  localparam int unsigned AXIS_BITS = COORD_BITS + 1;
  localparam int unsigned PROD_BITS = 2 * COORD_BITS + 1;
  localparam int unsigned PROJ_BITS = 2 * COORD_BITS + 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [AXIS_BITS-1:0]  axis_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [PROJ_BITS-1:0]  proj_t;

  // x0, y0, x1, y1, x2, y2, x3, y3
  typedef coord_t shape_t [NUM_COORDS];

  typedef struct packed {
    logic ld_proj;
    logic ld_span;
  } lane_ctrl_t;

  function automatic coord_t to_coord(logic [FIELD_BITS-1:0] f);
    logic [FIELD_BITS+COORD_BITS-1:0] ext;
    ext = {{COORD_BITS{1'b0}}, f};
    return coord_t'(ext[COORD_BITS-1:0]);
  endfunction

  function automatic proj_t project(axis_t ax, axis_t ay, coord_t px, coord_t py);
    prod_t prod_x;
    prod_t prod_y;
    prod_x = ax * px;
    prod_y = ay * py;
    return proj_t'(prod_x) + proj_t'(prod_y);
  endfunction

endpackage

// ===== src/qsat_lane.sv =====
// One axis: projects all eight corners, then spans of both shapes, then overlap.
module qsat_lane (
  input  logic                  clk_i,
  input  qsat_pkg::lane_ctrl_t  ctrl_i,
  input  qsat_pkg::axis_t       ax_i,
  input  qsat_pkg::axis_t       ay_i,
  input  qsat_pkg::shape_t      ref_i,
  input  qsat_pkg::shape_t      tst_i,
  output logic                  overlap_o
);

  qsat_pkg::proj_t proj_d [qsat_pkg::NUM_PROJ];
  qsat_pkg::proj_t proj_q [qsat_pkg::NUM_PROJ];

  qsat_pkg::proj_t lo_ref_d, hi_ref_d, lo_tst_d, hi_tst_d;
  qsat_pkg::proj_t lo_ref_q, hi_ref_q, lo_tst_q, hi_tst_q;

  // ref corners land in slots 0..3, test corners in 4..7
  always_comb begin
    for (int k = 0; k < qsat_pkg::NUM_CORNERS; k++) begin
      proj_d[k] = qsat_pkg::project(ax_i, ay_i, ref_i[2*k], ref_i[2*k+1]);
      proj_d[qsat_pkg::NUM_CORNERS+k] =
        qsat_pkg::project(ax_i, ay_i, tst_i[2*k], tst_i[2*k+1]);
    end
  end

  always_comb begin
    lo_ref_d = proj_q[0];
    hi_ref_d = proj_q[0];
    lo_tst_d = proj_q[qsat_pkg::NUM_CORNERS];
    hi_tst_d = proj_q[qsat_pkg::NUM_CORNERS];
    for (int k = 1; k < qsat_pkg::NUM_CORNERS; k++) begin
      if (proj_q[k] < lo_ref_d) lo_ref_d = proj_q[k];
      if (proj_q[k] > hi_ref_d) hi_ref_d = proj_q[k];
      if (proj_q[qsat_pkg::NUM_CORNERS+k] < lo_tst_d) lo_tst_d = proj_q[qsat_pkg::NUM_CORNERS+k];
      if (proj_q[qsat_pkg::NUM_CORNERS+k] > hi_tst_d) hi_tst_d = proj_q[qsat_pkg::NUM_CORNERS+k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_proj) begin
      proj_q <= proj_d;
    end
    if (ctrl_i.ld_span) begin
      lo_ref_q <= lo_ref_d;
      hi_ref_q <= hi_ref_d;
      lo_tst_q <= lo_tst_d;
      hi_tst_q <= hi_tst_d;
    end
  end

  // touching spans count as overlap
  assign overlap_o = !((hi_ref_q < lo_tst_q) || (hi_tst_q < lo_ref_q));

endmodule

// ===== src/quad_separating_axis_test.sv =====
// A test word passes the capture, axis, projection, span and result registers in turn; valid_o marks its overlap_o.
// One word is accepted per cycle while stall_o is low; a load word updates the reference at its edge, no result.
// Four pipeline stages: capture, axis edges, projections, spans; then the merged result.
// Reset (rst_ni low, async): all pipeline valid bits cleared, reference shape set to zeros.
module quad_separating_axis_test (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        operation_i,
  input  logic [15:0] corner0_x_i,
  input  logic [15:0] corner0_y_i,
  input  logic [15:0] corner1_x_i,
  input  logic [15:0] corner1_y_i,
  input  logic [15:0] corner2_x_i,
  input  logic [15:0] corner2_y_i,
  input  logic [15:0] corner3_x_i,
  input  logic [15:0] corner3_y_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        overlap_o
);

  // -------------------------------------------------------------------------
  // Input word unpacking
  // -------------------------------------------------------------------------
  qsat_pkg::shape_t in_pts;

  always_comb begin
    in_pts[0] = qsat_pkg::to_coord(corner0_x_i);
    in_pts[1] = qsat_pkg::to_coord(corner0_y_i);
    in_pts[2] = qsat_pkg::to_coord(corner1_x_i);
    in_pts[3] = qsat_pkg::to_coord(corner1_y_i);
    in_pts[4] = qsat_pkg::to_coord(corner2_x_i);
    in_pts[5] = qsat_pkg::to_coord(corner2_y_i);
    in_pts[6] = qsat_pkg::to_coord(corner3_x_i);
    in_pts[7] = qsat_pkg::to_coord(corner3_y_i);
  end

  // -------------------------------------------------------------------------
  // Flow control: each stage loads when it is empty or its contents move on.
  // Bubbles collapse, so the input keeps flowing while the output is held, until every stage is full.
  // -------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic ld2, ld3, ld4, ld5;
  logic accept;
  logic test_acc;

  assign rdy5 = !out_v_q || !stall_i;
  assign ld5  = v4_q && rdy5;
  assign rdy4 = !v4_q || rdy5;
  assign ld4  = v3_q && rdy4;
  assign rdy3 = !v3_q || rdy4;
  assign ld3  = v2_q && rdy3;
  assign rdy2 = !v2_q || rdy3;
  assign ld2  = v1_q && rdy2;
  assign rdy1 = !v1_q || rdy2;

  assign stall_o  = !rdy1;
  assign accept   = valid_i && rdy1;
  assign test_acc = accept && (operation_i == qsat_pkg::OP_TEST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1) v1_q    <= test_acc;
      if (rdy2) v2_q    <= ld2;
      if (rdy3) v3_q    <= ld3;
      if (rdy4) v4_q    <= ld4;
      if (rdy5) out_v_q <= ld5;
    end
  end

  // -------------------------------------------------------------------------
  // Reference shape: written by a load word at its accept edge. A test word
  // snapshots it on entry, so later loads never disturb a test in flight.
  // -------------------------------------------------------------------------
  qsat_pkg::shape_t ref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < qsat_pkg::NUM_COORDS; k++) begin
        ref_q[k] <= '0;
      end
    end else if (accept && (operation_i == qsat_pkg::OP_LOAD)) begin
      ref_q <= in_pts;
    end
  end

  // Stage 1: capture both shapes
  qsat_pkg::shape_t s1_ref_q, s1_tst_q;

  always_ff @(posedge clk_i) begin
    if (test_acc && rdy1) begin
      s1_ref_q <= ref_q;
      s1_tst_q <= in_pts;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: the four candidate axes, edges corner0->corner1 and
  // corner0->corner3 of each shape. Unnormalized; a zero edge never separates.
  // -------------------------------------------------------------------------
  qsat_pkg::axis_t  ax_d [qsat_pkg::NUM_AXES];
  qsat_pkg::axis_t  ay_d [qsat_pkg::NUM_AXES];
  qsat_pkg::axis_t  ax_q [qsat_pkg::NUM_AXES];
  qsat_pkg::axis_t  ay_q [qsat_pkg::NUM_AXES];
  qsat_pkg::shape_t s2_ref_q, s2_tst_q;

  always_comb begin
    ax_d[0] = qsat_pkg::axis_t'(s1_ref_q[2]) - qsat_pkg::axis_t'(s1_ref_q[0]);
    ay_d[0] = qsat_pkg::axis_t'(s1_ref_q[3]) - qsat_pkg::axis_t'(s1_ref_q[1]);
    ax_d[1] = qsat_pkg::axis_t'(s1_ref_q[6]) - qsat_pkg::axis_t'(s1_ref_q[0]);
    ay_d[1] = qsat_pkg::axis_t'(s1_ref_q[7]) - qsat_pkg::axis_t'(s1_ref_q[1]);
    ax_d[2] = qsat_pkg::axis_t'(s1_tst_q[2]) - qsat_pkg::axis_t'(s1_tst_q[0]);
    ay_d[2] = qsat_pkg::axis_t'(s1_tst_q[3]) - qsat_pkg::axis_t'(s1_tst_q[1]);
    ax_d[3] = qsat_pkg::axis_t'(s1_tst_q[6]) - qsat_pkg::axis_t'(s1_tst_q[0]);
    ay_d[3] = qsat_pkg::axis_t'(s1_tst_q[7]) - qsat_pkg::axis_t'(s1_tst_q[1]);
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      ax_q     <= ax_d;
      ay_q     <= ay_d;
      s2_ref_q <= s1_ref_q;
      s2_tst_q <= s1_tst_q;
    end
  end

  // -------------------------------------------------------------------------
  // Stages 3-4: one lane per axis (projections, then spans of both shapes).
  // -------------------------------------------------------------------------
  qsat_pkg::lane_ctrl_t        lane_ctrl;
  logic [qsat_pkg::NUM_AXES-1:0] axis_ovl;

  assign lane_ctrl.ld_proj = ld3;
  assign lane_ctrl.ld_span = ld4;

  for (genvar a = 0; a < qsat_pkg::NUM_AXES; a++) begin : g_lane
    qsat_lane u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl),
      .ax_i      (ax_q[a]),
      .ay_i      (ay_q[a]),
      .ref_i     (s2_ref_q),
      .tst_i     (s2_tst_q),
      .overlap_o (axis_ovl[a])
    );
  end

  // -------------------------------------------------------------------------
  // Merge: overlap only if no axis separates the shapes.
  // -------------------------------------------------------------------------
  logic overlap_q;

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      overlap_q <= &axis_ovl;
    end
  end

  assign valid_o   = out_v_q;
  assign overlap_o = overlap_q;

endmodule
